### src/hhfr_pkg.sv
`default_nettype none

package hhfr_pkg;

    localparam int BUFFER_DEPTH_DEFAULT = 2048;

    localparam int DATA_W = 8;
    localparam int ADDR_W = 11;
    localparam int LEN_W  = 12;
    localparam int POS_W  = 16;
    localparam int OFF_W  = 15;
    localparam int IDX_W  = 17;
    localparam int CFG_W  = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 12'd2000;
    localparam int HOLD_BYTES = 3;
    localparam int LOW_BYTES  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SESSION_ACTIVE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAGMENT_ENABLE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MESSAGE_LENGTH = 2'd2;

    typedef enum logic [2:0] {
        ST_MORE_FRAGMENTS = 3'd0,
        ST_MESSAGE_READY  = 3'd1,
        ST_BAD_OFFSET     = 3'd2,
        ST_BAD_LENGTH     = 3'd3,
        ST_NO_SESSION     = 3'd4,
        ST_READ_DATA      = 3'd5
    } t_status;

    typedef struct packed {
        logic              mode;
        logic [DATA_W-1:0] data_byte;
        logic              first_byte;
        logic              last_byte;
        logic [ADDR_W-1:0] read_address;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [LEN_W-1:0]  message_length;
        logic [DATA_W-1:0] read_data;
    } t_out_item;

    typedef struct packed {
        logic                              valid;
        logic                              is_read;
        t_status                           status;
        logic [LEN_W-1:0]                  mlen;
    } t_result;

    typedef struct packed {
        logic [LOW_BYTES-1:0]              we;
        logic [LOW_BYTES-1:0][DATA_W-1:0]  data;
    } t_low_wr;

endpackage

`default_nettype wire

### src/hhfr_store.sv
`default_nettype none

module hhfr_store #(
    parameter int BUFFER_DEPTH = hhfr_pkg::BUFFER_DEPTH_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire hhfr_pkg::t_low_wr             i_low_wr,
    input  wire logic                          i_mem_we,
    input  wire logic [$clog2(BUFFER_DEPTH)-1:0] i_mem_idx,
    input  wire logic [hhfr_pkg::DATA_W-1:0]   i_mem_data,
    input  wire logic                          i_rd_en,
    input  wire logic [hhfr_pkg::ADDR_W-1:0]   i_rd_addr,
    output logic [hhfr_pkg::DATA_W-1:0]        o_rd_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    // indices 0..3 live in flops so all held header bytes can be written at once
    logic [hhfr_pkg::DATA_W-1:0] mem [BUFFER_DEPTH];
    logic [hhfr_pkg::DATA_W-1:0] r_low [hhfr_pkg::LOW_BYTES];
    logic [hhfr_pkg::DATA_W-1:0] r_mem_q;
    logic [hhfr_pkg::DATA_W-1:0] r_low_q;
    logic                        r_sel_low;
    logic                        r_zero;

    always_ff @(posedge i_clk) begin
        if (i_mem_we) begin
            mem[i_mem_idx] <= i_mem_data;
        end
        if (i_rd_en) begin
            r_mem_q <= mem[AW'(i_rd_addr)];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < hhfr_pkg::LOW_BYTES; j++) begin
            if (i_low_wr.we[j]) begin
                r_low[j] <= i_low_wr.data[j];
            end
        end
        if (i_rd_en) begin
            r_low_q   <= r_low[i_rd_addr[1:0]];
            r_sel_low <= (i_rd_addr < hhfr_pkg::ADDR_W'(hhfr_pkg::LOW_BYTES));
            r_zero    <= (hhfr_pkg::IDX_W'(i_rd_addr) >= hhfr_pkg::IDX_W'(BUFFER_DEPTH));
        end
    end

    assign o_rd_data = r_zero    ? '0      :
                       r_sel_low ? r_low_q : r_mem_q;

endmodule

`default_nettype wire

### src/hhfr_ctrl.sv
`default_nettype none

module hhfr_ctrl #(
    parameter int BUFFER_DEPTH = hhfr_pkg::BUFFER_DEPTH_DEFAULT
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_fire,
    input  wire hhfr_pkg::t_in_item               i_item,
    input  wire logic                             i_cfg_we,
    input  wire logic [hhfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [hhfr_pkg::CFG_W-1:0]       i_cfg_data,
    output hhfr_pkg::t_low_wr                     o_low_wr,
    output logic                                  o_mem_we,
    output logic [$clog2(BUFFER_DEPTH)-1:0]       o_mem_idx,
    output logic [hhfr_pkg::DATA_W-1:0]           o_mem_data,
    output hhfr_pkg::t_result                     o_result
);

    localparam int AW    = $clog2(BUFFER_DEPTH);
    localparam int IDX_W = hhfr_pkg::IDX_W;
    localparam int LEN_W = hhfr_pkg::LEN_W;
    localparam int OFF_W = hhfr_pkg::OFF_W;
    localparam int POS_W = hhfr_pkg::POS_W;

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic offset_bad(input logic [OFF_W-1:0] off,
                                        input logic [LEN_W-1:0] reas,
                                        input logic [LEN_W-1:0] max_len);
        return ((off != '0) && (off != OFF_W'(reas))) || (off > OFF_W'(max_len));
    endfunction

    logic                              r_session;
    logic                              r_frag_en;
    logic [LEN_W-1:0]                  r_max;
    logic [POS_W-1:0]                  r_pos;
    logic [POS_W-1:0]                  n_pos;
    logic [hhfr_pkg::DATA_W-1:0]       r_hold [hhfr_pkg::HOLD_BYTES];
    logic [hhfr_pkg::DATA_W-1:0]       n_hold [hhfr_pkg::HOLD_BYTES];
    logic                              r_frag, n_frag;
    logic                              r_final, n_final;
    logic                              r_over, n_over;
    logic [OFF_W-1:0]                  r_frag_off, n_frag_off;
    logic [LEN_W-1:0]                  r_reas, n_reas;

    always_comb begin
        logic [POS_W-1:0]  pos;
        logic [7:0]        b;
        logic              frag, final_f, over;
        logic [4:0]        nb0, nb1, nb2, nb3;
        logic              hdr_ok;
        logic [15:0]       dec_v;
        logic              put_req;
        logic [IDX_W-1:0]  put_idx;
        logic [OFF_W-1:0]  cur_off;
        logic [IDX_W-1:0]  total;

        n_pos      = r_pos;
        n_hold     = r_hold;
        n_frag     = r_frag;
        n_final    = r_final;
        n_over     = r_over;
        n_frag_off = r_frag_off;
        n_reas     = r_reas;
        o_low_wr   = '0;
        o_mem_we   = 1'b0;
        o_mem_idx  = '0;
        o_result   = '0;

        b       = i_item.data_byte;
        o_mem_data = b;
        pos     = i_item.first_byte ? '0   : r_pos;
        frag    = i_item.first_byte ? 1'b0 : r_frag;
        final_f = i_item.first_byte ? 1'b0 : r_final;
        over    = i_item.first_byte ? 1'b0 : r_over;

        nb0    = hex_nibble(r_hold[0]);
        nb1    = hex_nibble(r_hold[1]);
        nb2    = hex_nibble(r_hold[2]);
        nb3    = hex_nibble(b);
        hdr_ok = r_frag_en & nb0[4] & nb1[4] & nb2[4] & nb3[4];
        dec_v  = {nb0[3:0], nb1[3:0], nb2[3:0], nb3[3:0]};

        put_req = 1'b0;
        put_idx = '0;
        cur_off = '0;
        total   = '0;

        if (i_fire && i_item.mode) begin
            o_result.valid   = 1'b1;
            o_result.is_read = 1'b1;
            o_result.status  = hhfr_pkg::ST_READ_DATA;
        end else if (i_fire) begin
            if (pos < POS_W'(4)) begin
                if (pos < POS_W'(3)) begin
                    for (int j = 0; j < hhfr_pkg::HOLD_BYTES; j++) begin
                        if (pos[1:0] == 2'(j)) begin
                            n_hold[j] = b;
                        end
                    end
                end else if (hdr_ok) begin
                    frag       = 1'b1;
                    final_f    = dec_v[15];
                    n_frag_off = dec_v[14:0];
                end else begin
                    for (int j = 0; j < hhfr_pkg::LOW_BYTES; j++) begin
                        if (LEN_W'(j) >= r_max) begin
                            over = 1'b1;
                        end else if (r_session) begin
                            o_low_wr.we[j]   = 1'b1;
                            o_low_wr.data[j] = (j == 3) ? b : r_hold[j % 3];
                        end
                    end
                end
            end else if (frag) begin
                if (!offset_bad(r_frag_off, r_reas, r_max)) begin
                    put_req = 1'b1;
                    put_idx = IDX_W'(r_frag_off) + IDX_W'(pos - POS_W'(4));
                end
            end else begin
                put_req = 1'b1;
                put_idx = IDX_W'(pos);
            end

            if (put_req) begin
                if (put_idx >= IDX_W'(r_max)) begin
                    over = 1'b1;
                end else if (r_session) begin
                    if (put_idx < IDX_W'(hhfr_pkg::LOW_BYTES)) begin
                        o_low_wr.we[put_idx[1:0]]   = 1'b1;
                        o_low_wr.data[put_idx[1:0]] = b;
                    end else if (put_idx < IDX_W'(BUFFER_DEPTH)) begin
                        o_mem_we  = 1'b1;
                        o_mem_idx = AW'(put_idx);
                    end
                end
            end

            n_pos   = (pos == '1) ? pos : pos + POS_W'(1);
            n_frag  = frag;
            n_final = final_f;

            if (i_item.last_byte) begin
                o_result.valid = 1'b1;
                cur_off = (pos == POS_W'(3)) ? dec_v[14:0] : r_frag_off;
                total   = IDX_W'(cur_off) + IDX_W'(pos) - IDX_W'(3);
                if (!r_session) begin
                    o_result.status = hhfr_pkg::ST_NO_SESSION;
                end else if (frag) begin
                    if (offset_bad(cur_off, r_reas, r_max)) begin
                        o_result.status = hhfr_pkg::ST_BAD_OFFSET;
                        n_reas = '0;
                    end else if (over) begin
                        o_result.status = hhfr_pkg::ST_BAD_LENGTH;
                        n_reas = '0;
                    end else if (final_f) begin
                        o_result.status = hhfr_pkg::ST_MESSAGE_READY;
                        o_result.mlen   = total[LEN_W-1:0];
                        n_reas = '0;
                    end else begin
                        o_result.status = hhfr_pkg::ST_MORE_FRAGMENTS;
                        n_reas = total[LEN_W-1:0];
                    end
                end else begin
                    if (pos < POS_W'(3)) begin
                        for (int j = 0; j < hhfr_pkg::HOLD_BYTES; j++) begin
                            if (POS_W'(j) <= pos) begin
                                if (LEN_W'(j) >= r_max) begin
                                    over = 1'b1;
                                end else begin
                                    o_low_wr.we[j]   = 1'b1;
                                    o_low_wr.data[j] = (pos[1:0] == 2'(j)) ? b : r_hold[j];
                                end
                            end
                        end
                    end
                    if (over) begin
                        o_result.status = hhfr_pkg::ST_BAD_LENGTH;
                    end else begin
                        o_result.status = hhfr_pkg::ST_MESSAGE_READY;
                        o_result.mlen   = pos[LEN_W-1:0] + LEN_W'(1);
                    end
                    n_reas = '0;
                end
                n_pos   = '0;
                n_frag  = 1'b0;
                n_final = 1'b0;
                over    = 1'b0;
            end
            n_over = over;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session  <= 1'b0;
            r_frag_en  <= 1'b0;
            r_max      <= hhfr_pkg::MAX_LEN_RESET;
            r_pos      <= '0;
            r_frag     <= 1'b0;
            r_final    <= 1'b0;
            r_over     <= 1'b0;
            r_frag_off <= '0;
            r_reas     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    hhfr_pkg::CFG_SESSION_ACTIVE:     r_session <= i_cfg_data[0];
                    hhfr_pkg::CFG_FRAGMENT_ENABLE:    r_frag_en <= i_cfg_data[0];
                    hhfr_pkg::CFG_MAX_MESSAGE_LENGTH: r_max     <= i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            r_pos      <= n_pos;
            r_frag     <= n_frag;
            r_final    <= n_final;
            r_over     <= n_over;
            r_frag_off <= n_frag_off;
            r_reas     <= n_reas;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
    end

endmodule

`default_nettype wire

### src/hhfr_out_stage.sv
`default_nettype none

module hhfr_out_stage (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire hhfr_pkg::t_result           i_result,
    input  wire logic [hhfr_pkg::DATA_W-1:0] i_rd_data,
    input  wire logic                        i_out_stall,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output hhfr_pkg::t_out_item              o_out_item
);

    logic              r_a_valid;
    hhfr_pkg::t_result r_a;
    logic              r_o_valid;
    hhfr_pkg::t_out_item r_o;
    logic              advance;

    // stage A waits for the registered store read, then moves to the output
    assign advance    = r_a_valid && (!r_o_valid || !i_out_stall);
    assign o_in_stall = r_a_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_result.valid) begin
                r_a_valid <= 1'b1;
            end else if (advance) begin
                r_a_valid <= 1'b0;
            end
            if (advance) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.valid) begin
            r_a <= i_result;
        end
        if (advance) begin
            r_o.status         <= r_a.status;
            r_o.message_length <= r_a.mlen;
            r_o.read_data      <= r_a.is_read ? i_rd_data : '0;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_item  = r_o;

endmodule

`default_nettype wire

### src/hex_header_fragment_reassembler_unit.sv
// Each result is registered in stage A, then moves on into the output register.
// One item per cycle unless stalled; the message store has one write and one read port.
// Input stall rises only while both stages hold results and i_out_stall is high.
// Reset (i_rst_n, synchronous, active low) clears handshake and reassembly state and
// returns configuration to its reset values; message store contents are not cleared.
`default_nettype none

module hex_header_fragment_reassembler_unit #(
    parameter int BUFFER_DEPTH = hhfr_pkg::BUFFER_DEPTH_DEFAULT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire hhfr_pkg::t_in_item             i_in_item,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output hhfr_pkg::t_out_item                 o_out_item,
    input  wire logic                           i_cfg_we,
    input  wire logic [hhfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [hhfr_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic                        fire;
    hhfr_pkg::t_low_wr           low_wr;
    logic                        mem_we;
    logic [AW-1:0]               mem_idx;
    logic [hhfr_pkg::DATA_W-1:0] mem_data;
    hhfr_pkg::t_result           result;
    logic [hhfr_pkg::DATA_W-1:0] rd_data;

    assign fire = i_in_valid && !o_in_stall;

    hhfr_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_low_wr    (low_wr),
        .o_mem_we    (mem_we),
        .o_mem_idx   (mem_idx),
        .o_mem_data  (mem_data),
        .o_result    (result)
    );

    hhfr_store #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk      (i_clk),
        .i_low_wr   (low_wr),
        .i_mem_we   (mem_we),
        .i_mem_idx  (mem_idx),
        .i_mem_data (mem_data),
        .i_rd_en    (fire && i_in_item.mode),
        .i_rd_addr  (i_in_item.read_address),
        .o_rd_data  (rd_data)
    );

    hhfr_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_result    (result),
        .i_rd_data   (rd_data),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps

class reassembly_scoreboard;
    bit [7:0]                      image [hhfr_pkg::BUFFER_DEPTH_DEFAULT];
    bit                            filled [hhfr_pkg::BUFFER_DEPTH_DEFAULT];
    int unsigned                   filled_addrs [$];
    bit [hhfr_pkg::LEN_W-1:0]      run_offset;
    bit [31:0]                     held_chars;
    bit [hhfr_pkg::POS_W-1:0]      byte_pos;
    bit                            is_frag;
    bit                            is_final;
    bit                            over;
    bit                            session_on;
    bit                            frag_on;
    bit [hhfr_pkg::LEN_W-1:0]      len_limit;
    hhfr_pkg::t_out_item           due_results [$];
    int                            failures;

    function new();
        run_offset = '0;
        held_chars = '0;
        byte_pos   = '0;
        is_frag    = 1'b0;
        is_final   = 1'b0;
        over       = 1'b0;
        session_on = 1'b0;
        frag_on    = 1'b0;
        len_limit  = hhfr_pkg::MAX_LEN_RESET;
        failures   = 0;
    endfunction

    function void set_register(bit [hhfr_pkg::CFG_IDX_W-1:0] idx,
                               bit [hhfr_pkg::CFG_W-1:0] value);
        case (idx)
            hhfr_pkg::CFG_SESSION_ACTIVE:     session_on = value[0];
            hhfr_pkg::CFG_FRAGMENT_ENABLE:    frag_on    = value[0];
            hhfr_pkg::CFG_MAX_MESSAGE_LENGTH: len_limit  = value;
            default: ;
        endcase
    endfunction

    function int hex_value(bit [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
        if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
        return -1;
    endfunction

    function void store_byte(int unsigned idx, bit [7:0] b);
        if (idx >= len_limit) begin
            over = 1'b1;
            return;
        end
        if (session_on && idx < hhfr_pkg::BUFFER_DEPTH_DEFAULT) begin
            image[idx] = b;
            if (!filled[idx]) begin
                filled[idx] = 1'b1;
                filled_addrs.push_back(idx);
            end
        end
    endfunction

    // held bytes go to 0..count-1, most recent byte in the low bits
    function void release_held(int unsigned count);
        int unsigned k;
        for (k = 0; k < count; k++)
            store_byte(k, 8'(held_chars >> ((count - 1 - k) * 8)));
    endfunction

    function bit offset_rejected(int unsigned off);
        int unsigned want;
        want = (off == 0) ? 0 : run_offset;
        return (off != want) || (off > len_limit);
    endfunction

    function void absorb_item(hhfr_pkg::t_in_item it);
        hhfr_pkg::t_out_item res;
        int unsigned p;
        int unsigned off;
        int unsigned total;
        int          n;
        int          k;
        bit          ok;
        bit [15:0]   v;
        res = '0;
        if (it.mode) begin
            res.status    = hhfr_pkg::ST_READ_DATA;
            res.read_data = image[it.read_address];
            due_results.push_back(res);
            return;
        end
        if (it.first_byte) begin
            byte_pos   = '0;
            held_chars = '0;
            is_frag    = 1'b0;
            is_final   = 1'b0;
            over       = 1'b0;
        end
        p = byte_pos;
        if (p < 4) begin
            held_chars = {held_chars[23:0], it.data_byte};
            if (p == 3) begin
                ok = frag_on;
                v  = '0;
                for (k = 3; k >= 0; k--) begin
                    n = hex_value(held_chars[8*k +: 8]);
                    if (n < 0) ok = 1'b0;
                    v = {v[11:0], n[3:0]};
                end
                if (ok) begin
                    held_chars = {v, 16'h0001};
                    is_frag    = 1'b1;
                    is_final   = v[15];
                end else begin
                    release_held(4);
                end
            end
        end else if (is_frag) begin
            off = held_chars[30:16];
            if (!offset_rejected(off)) store_byte(off + p - 4, it.data_byte);
        end else begin
            store_byte(p, it.data_byte);
        end
        if (byte_pos != 16'hFFFF) byte_pos++;
        if (!it.last_byte) return;

        if (!session_on) begin
            res.status = hhfr_pkg::ST_NO_SESSION;
        end else if (is_frag) begin
            off = held_chars[30:16];
            if (offset_rejected(off)) begin
                res.status = hhfr_pkg::ST_BAD_OFFSET;
                run_offset = '0;
            end else if (over) begin
                res.status = hhfr_pkg::ST_BAD_LENGTH;
                run_offset = '0;
            end else begin
                total = off + p - 3;
                if (is_final) begin
                    res.status         = hhfr_pkg::ST_MESSAGE_READY;
                    res.message_length = total[hhfr_pkg::LEN_W-1:0];
                    run_offset         = '0;
                end else begin
                    res.status = hhfr_pkg::ST_MORE_FRAGMENTS;
                    run_offset = total[hhfr_pkg::LEN_W-1:0];
                end
            end
        end else begin
            if (p < 3) release_held(p + 1);
            if (over) begin
                res.status = hhfr_pkg::ST_BAD_LENGTH;
            end else begin
                res.status         = hhfr_pkg::ST_MESSAGE_READY;
                res.message_length = hhfr_pkg::LEN_W'(p + 1);
            end
            run_offset = '0;
        end
        byte_pos   = '0;
        held_chars = '0;
        is_frag    = 1'b0;
        is_final   = 1'b0;
        over       = 1'b0;
        due_results.push_back(res);
    endfunction

    function void log_failure(string msg);
        failures++;
        if (failures <= 10) $display("%s", msg);
    endfunction

    function void check_result(hhfr_pkg::t_out_item got);
        hhfr_pkg::t_out_item want;
        if (due_results.size() == 0) begin
            log_failure($sformatf("unexpected transfer: status=%0d len=%0d data=%02h",
                                  got.status, got.message_length, got.read_data));
            return;
        end
        want = due_results.pop_front();
        if (got.status !== want.status || got.message_length !== want.message_length ||
            got.read_data !== want.read_data)
            log_failure($sformatf(
                "mismatch: expected status=%0d len=%0d data=%02h, got status=%0d len=%0d data=%02h",
                want.status, want.message_length, want.read_data,
                got.status, got.message_length, got.read_data));
    endfunction
endclass

module testbench;
    localparam int CYCLE_LIMIT = 300000;

    logic                           i_clk     = 1'b0;
    logic                           i_rst_n   = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           out_stall = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [hhfr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [hhfr_pkg::CFG_W-1:0]     cfg_data  = '0;
    hhfr_pkg::t_in_item             in_item   = '0;
    logic                           in_stall;
    logic                           out_valid;
    hhfr_pkg::t_out_item            out_item;

    int sender_idle_pct   = 9;
    int receiver_idle_pct = 50;
    bit hold_req          = 1'b0;
    int hold_left         = 0;
    int items_sent        = 0;
    int cycle_count       = 0;

    reassembly_scoreboard sb = new();

    hex_header_fragment_reassembler_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && !in_stall) sb.absorb_item(in_item);
        if (i_rst_n && out_valid && !out_stall) sb.check_result(out_item);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = 150;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    function automatic hhfr_pkg::t_in_item byte_item(bit [7:0] b, bit first, bit last);
        hhfr_pkg::t_in_item it;
        it.mode         = 1'b0;
        it.data_byte    = b;
        it.first_byte   = first;
        it.last_byte    = last;
        it.read_address = hhfr_pkg::ADDR_W'($urandom());
        return it;
    endfunction

    function automatic hhfr_pkg::t_in_item read_item(bit [hhfr_pkg::ADDR_W-1:0] addr);
        hhfr_pkg::t_in_item it;
        it.mode         = 1'b1;
        it.data_byte    = hhfr_pkg::DATA_W'($urandom());
        it.first_byte   = 1'($urandom_range(1));
        it.last_byte    = 1'($urandom_range(1));
        it.read_address = addr;
        return it;
    endfunction

    function automatic bit [7:0] hex_char(bit [3:0] n);
        if (n < 10) return 8'h30 + 8'(n);
        return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + n - 10);
    endfunction

    task automatic push_item(input hhfr_pkg::t_in_item it);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_bytes(input bit [7:0] bytes[$], input bit with_first,
                              input bit with_last);
        int i;
        for (i = 0; i < bytes.size(); i++)
            push_item(byte_item(bytes[i], with_first && i == 0,
                                with_last && i == bytes.size() - 1));
    endtask

    // low n bytes of word, most significant first
    task automatic send_packed(input bit [63:0] word, input int n);
        int i;
        for (i = n - 1; i >= 0; i--)
            push_item(byte_item(word[8*i +: 8], i == n - 1, i == 0));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.due_results.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic apply_settings(input bit sess, input bit frag, input int max_len);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= hhfr_pkg::CFG_SESSION_ACTIVE;
        cfg_data  <= hhfr_pkg::CFG_W'(sess);
        @(negedge i_clk);
        cfg_index <= hhfr_pkg::CFG_FRAGMENT_ENABLE;
        cfg_data  <= hhfr_pkg::CFG_W'(frag);
        @(negedge i_clk);
        cfg_index <= hhfr_pkg::CFG_MAX_MESSAGE_LENGTH;
        cfg_data  <= hhfr_pkg::CFG_W'(max_len);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        sb.set_register(hhfr_pkg::CFG_SESSION_ACTIVE, hhfr_pkg::CFG_W'(sess));
        sb.set_register(hhfr_pkg::CFG_FRAGMENT_ENABLE, hhfr_pkg::CFG_W'(frag));
        sb.set_register(hhfr_pkg::CFG_MAX_MESSAGE_LENGTH, hhfr_pkg::CFG_W'(max_len));
    endtask

    task automatic send_read();
        if (sb.filled_addrs.size() == 0) return;
        push_item(read_item(hhfr_pkg::ADDR_W'(
            sb.filled_addrs[$urandom_range(0, sb.filled_addrs.size() - 1)])));
    endtask

    task automatic send_fragments();
        bit [7:0]  q[$];
        bit [14:0] off;
        bit [15:0] hdr;
        int        count, len, room, f, s, i;
        count = $urandom_range(1, 3);
        for (f = 0; f < count; f++) begin
            q.delete();
            off = (f == 0) ? 15'd0 : 15'(sb.run_offset);
            if ($urandom_range(99) < 8) off = 15'($urandom());
            else if ($urandom_range(99) < 5) off = off + 15'($urandom_range(1, 3));
            room = int'(sb.len_limit) - int'(off);
            if (room < 0) room = 0;
            len = $urandom_range(0, room < 10 ? room : 10);
            if (room <= 40 && $urandom_range(99) < 10) len = room + $urandom_range(1, 3);
            hdr = {f == count - 1, off};
            for (s = 12; s >= 0; s -= 4) q.push_back(hex_char(hdr[s +: 4]));
            for (i = 0; i < len; i++) q.push_back(8'($urandom()));
            send_bytes(q, 1'b1, 1'b1);
        end
    endtask

    task automatic send_whole();
        bit [7:0] q[$];
        int       len, i;
        len = $urandom_range(1, 12);
        if (sb.len_limit <= 24 && $urandom_range(99) < 15)
            len = sb.len_limit + $urandom_range(0, 2);
        for (i = 0; i < len; i++) q.push_back(8'($urandom()));
        send_bytes(q, 1'b1, 1'b1);
    endtask

    task automatic send_noise();
        bit [7:0] q[$];
        bit [7:0] near_hex [6];
        int       len, i;
        near_hex = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};
        len = $urandom_range(1, 6);
        case ($urandom_range(3))
            0: begin
                for (i = 0; i < 4; i++) q.push_back(hex_char(4'($urandom())));
                q[$urandom_range(0, 3)] = near_hex[$urandom_range(0, 5)];
                for (i = 0; i < len - 3; i++) q.push_back(8'($urandom()));
                send_bytes(q, 1'b1, 1'b1);
            end
            1: begin
                for (i = 0; i < len; i++) q.push_back(8'($urandom()));
                send_bytes(q, 1'b0, 1'b1);
            end
            2: begin
                for (i = 0; i < len; i++) q.push_back(hex_char(4'($urandom())));
                send_bytes(q, 1'b1, 1'b0);
            end
            default: begin
                for (i = 0; i < len + 2; i++)
                    push_item(byte_item(8'($urandom()), 1'($urandom_range(1)),
                                        1'($urandom_range(1))));
            end
        endcase
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            case ($urandom_range(9))
                0, 1:       send_read();
                2, 3, 4, 5: send_fragments();
                6, 7:       send_whole();
                default:    send_noise();
            endcase
        end
    endtask

    initial begin
        bit [7:0] long_q[$];
        int       i;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // no session after reset
        send_packed(64'h41, 1);
        apply_settings(1'b1, 1'b1, 4);
        send_packed(64'h00FF, 2);
        push_item(byte_item(8'h7E, 1'b0, 1'b1));
        send_packed({"0000", 8'h12}, 5);
        send_packed({"8001", 8'h34}, 5);
        send_packed({"80aF", 8'h55}, 5);
        send_packed("g123", 4);
        send_packed({"G000", 8'h99}, 5);
        push_item(read_item(11'd0));
        push_item(read_item(11'd1));
        push_item(read_item(11'd3));

        // long message, overflowing by one byte
        apply_settings(1'b1, 1'b0, 600);
        for (i = 0; i < 601; i++) long_q.push_back(8'($urandom()));
        send_bytes(long_q, 1'b1, 1'b1);
        push_item(read_item(11'd599));
        push_item(read_item(11'd300));

        apply_settings(1'b1, 1'b1, 2048);
        run_random(100);
        apply_settings(1'b1, 1'b1, 24);
        run_random(100);

        settle();
        sender_idle_pct   = 50;
        receiver_idle_pct = 9;
        apply_settings(1'b1, 1'b0, 2000);
        run_random(70);
        apply_settings(1'b0, 1'b1, 16);
        run_random(50);
        apply_settings(1'b1, 1'b1, 1);
        run_random(70);

        settle();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        apply_settings(1'b1, 1'b1, 40);
        run_random(70);
        hold_req = 1'b1;
        run_random(100);

        settle();
        repeat (10) @(negedge i_clk);
        if (sb.failures == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
